>>> hdl/acmac_pkg.sv
package acmac_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_SUBK,
    ST_LOAD,
    ST_RUN,
    ST_OUT
  } state_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [7:0] RB_CONST = 8'h87;

  typedef logic [7:0] sbox_tbl_t [256];

  localparam sbox_tbl_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] a);
    logic [127:0] v;
    v = {a[126:0], 1'b0};
    if (a[127]) v[7:0] = v[7:0] ^ RB_CONST;
    return v;
  endfunction

endpackage

>>> hdl/aes128_cmac_tag_core.sv
// AES-128 CMAC (RFC 4493) engine. One 16-byte block per input beat; the tag
// beat follows the last block. From its accept to the next ready a block goes
// through accept, load, ten rounds of the shared round unit and output, in
// the round-iterative AES datapath. A tag beat still waiting on out_ready
// holds the next block in its output cycle until the tag is taken.
// After reset or any key write, the first block first runs the key schedule
// and then the subkey encryption of the zero block.
module aes128_cmac_tag_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [63:0]  in_block_upper,
  input  logic [63:0]  in_block_lower,
  input  logic [4:0]   in_byte_count,
  input  logic         in_last_block,
  input  logic         in_check_tag,
  input  logic [63:0]  in_expected_upper,
  input  logic [63:0]  in_expected_lower,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [63:0]  out_tag_upper,
  output logic [63:0]  out_tag_lower,
  output logic         out_tag_match
);

  acmac_pkg::state_t state_r, state_nxt;
  logic [127:0] key_r, chain_r, k1_r, k2_r, st_r, kw_r, blk_r, exp_r;
  logic [4:0]   cnt_r;
  logic         last_r, chk_r, ready_r;
  logic [3:0]   rnd_r;
  logic [127:0] rk_mem [11];
  logic [127:0] rk_q;
  logic [127:0] rnd_out, knext, msg;
  logic         out_valid_r;
  logic [127:0] tag_r;
  logic         match_r;

  assign in_ready = (state_r == acmac_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_tag_upper = tag_r[127:64];
  assign out_tag_lower = tag_r[63:0];
  assign out_tag_match = match_r;

  acmac_round u_round (
    .state_i(st_r), .rkey_i(rk_q), .final_i(rnd_r == 4'd10),
    .kprev_i(kw_r), .knum_i(rnd_r + 4'd1), .state_o(rnd_out), .knext_o(knext)
  );

  // read port runs one round ahead
  always_ff @(posedge clk) begin
    if (state_r == acmac_pkg::ST_KEXP) rk_mem[rnd_r] <= kw_r;
    rk_q <= rk_mem[(state_r == acmac_pkg::ST_RUN || state_r == acmac_pkg::ST_SUBK)
                   ? ((rnd_r == 4'd10) ? 4'd0 : rnd_r + 4'd1) : 4'd1];
  end

  always_comb begin
    msg = blk_r;
    if (last_r) begin
      if (cnt_r[4]) msg = blk_r ^ k1_r;
      else begin
        for (int i = 0; i < 16; i++)
          if (i[4:0] == cnt_r) msg[127-8*i -: 8] = acmac_pkg::PAD_MARK;
          else if (i[4:0] > cnt_r) msg[127-8*i -: 8] = 8'h00;
        msg = msg ^ k2_r;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acmac_pkg::ST_IDLE: if (in_valid) state_nxt = ready_r ? acmac_pkg::ST_LOAD : acmac_pkg::ST_KEXP;
      acmac_pkg::ST_KEXP: if (rnd_r == 4'd10) state_nxt = acmac_pkg::ST_SUBK;
      acmac_pkg::ST_SUBK: if (rnd_r == 4'd10) state_nxt = acmac_pkg::ST_LOAD;
      acmac_pkg::ST_LOAD: state_nxt = acmac_pkg::ST_RUN;
      acmac_pkg::ST_RUN:  if (rnd_r == 4'd10) state_nxt = acmac_pkg::ST_OUT;
      acmac_pkg::ST_OUT:  if (!out_valid_r || out_ready) state_nxt = acmac_pkg::ST_IDLE;
      default: state_nxt = acmac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acmac_pkg::ST_IDLE;
      ready_r <= 1'b0;
      out_valid_r <= 1'b0;
      key_r <= '0;
      chain_r <= '0;
      k1_r <= '0;
      k2_r <= '0;
    end else begin
      state_r <= state_nxt;
      // a new tag beat replaces one that is taken in the same cycle
      if (state_r == acmac_pkg::ST_OUT && last_r && (!out_valid_r || out_ready))
        out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        ready_r <= 1'b0;
        if (cfg_index == 1'b0) key_r[127:64] <= cfg_data;
        else key_r[63:0] <= cfg_data;
      end
      unique case (state_r)
        acmac_pkg::ST_IDLE: if (in_valid) begin
          blk_r <= {in_block_upper, in_block_lower};
          exp_r <= {in_expected_upper, in_expected_lower};
          cnt_r <= in_byte_count;
          last_r <= in_last_block;
          chk_r <= in_check_tag;
          kw_r <= key_r;
          rnd_r <= 4'd0;
        end
        acmac_pkg::ST_KEXP: begin
          kw_r <= knext;
          if (rnd_r == 4'd10) begin
            rnd_r <= 4'd1;
            st_r <= rk_mem[0];
          end else rnd_r <= rnd_r + 4'd1;
        end
        acmac_pkg::ST_SUBK: begin
          st_r <= rnd_out;
          rnd_r <= rnd_r + 4'd1;
          if (rnd_r == 4'd10) begin
            k1_r <= acmac_pkg::dbl(rnd_out);
            k2_r <= acmac_pkg::dbl(acmac_pkg::dbl(rnd_out));
            ready_r <= 1'b1;
          end
        end
        acmac_pkg::ST_LOAD: begin
          st_r <= msg ^ chain_r ^ rk_mem[0];
          rnd_r <= 4'd1;
        end
        acmac_pkg::ST_RUN: begin
          st_r <= rnd_out;
          rnd_r <= rnd_r + 4'd1;
        end
        acmac_pkg::ST_OUT: if (!out_valid_r || out_ready) begin
          if (last_r) begin
            chain_r <= '0;
            tag_r <= st_r;
            match_r <= chk_r && (st_r == exp_r);
          end else chain_r <= st_r;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/acmac_round.sv
// One AES round, or one key-schedule step, per cycle.
module acmac_round (
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  input  logic         final_i,
  input  logic [127:0] kprev_i,
  input  logic [3:0]   knum_i,
  output logic [127:0] state_o,
  output logic [127:0] knext_o
);

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  logic [7:0] s  [16];
  logic [7:0] sh [16];
  logic [7:0] mc [16];
  logic [31:0] w3, tw;

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = acmac_pkg::SBOX[state_i[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) sh[i+4*c] = s[i + 4*((c+i) & 3)];
    for (int c = 0; c < 4; c++) begin
      mc[4*c]   = sh[4*c]   ^ (sh[4*c]^sh[4*c+1]^sh[4*c+2]^sh[4*c+3]) ^ xt(sh[4*c]^sh[4*c+1]);
      mc[4*c+1] = sh[4*c+1] ^ (sh[4*c]^sh[4*c+1]^sh[4*c+2]^sh[4*c+3]) ^ xt(sh[4*c+1]^sh[4*c+2]);
      mc[4*c+2] = sh[4*c+2] ^ (sh[4*c]^sh[4*c+1]^sh[4*c+2]^sh[4*c+3]) ^ xt(sh[4*c+2]^sh[4*c+3]);
      mc[4*c+3] = sh[4*c+3] ^ (sh[4*c]^sh[4*c+1]^sh[4*c+2]^sh[4*c+3]) ^ xt(sh[4*c+3]^sh[4*c]);
    end
    for (int i = 0; i < 16; i++)
      state_o[127-8*i -: 8] = (final_i ? sh[i] : mc[i]) ^ rkey_i[127-8*i -: 8];

    w3 = kprev_i[31:0];
    tw = {acmac_pkg::SBOX[w3[23:16]] ^ acmac_pkg::rcon(knum_i), acmac_pkg::SBOX[w3[15:8]],
          acmac_pkg::SBOX[w3[7:0]], acmac_pkg::SBOX[w3[31:24]]};
    knext_o[127:96] = kprev_i[127:96] ^ tw;
    knext_o[95:64]  = kprev_i[95:64] ^ knext_o[127:96];
    knext_o[63:32]  = kprev_i[63:32] ^ knext_o[95:64];
    knext_o[31:0]   = kprev_i[31:0] ^ knext_o[63:32];
  end

endmodule

>>> bench/aes128_cmac_tag_core_tb.sv
module aes128_cmac_tag_core_tb;

  localparam logic [0:0] KEY_UPPER_REG = 1'b0;
  localparam logic [0:0] KEY_LOWER_REG = 1'b1;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLDOFF_CYCLES = 400;

  typedef struct {
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
    logic [4:0]  count;
    logic        last;
    logic        check;
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } block_beat_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        match;
  } tag_beat_t;

  typedef logic [10:0][127:0] round_keys_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [63:0] in_block_upper = '0;
  logic [63:0] in_block_lower = '0;
  logic [4:0] in_byte_count = '0;
  logic in_last_block = 1'b0;
  logic in_check_tag = 1'b0;
  logic [63:0] in_expected_upper = '0;
  logic [63:0] in_expected_lower = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] out_tag_upper;
  logic [63:0] out_tag_lower;
  logic out_tag_match;

  aes128_cmac_tag_core uut (.*);

  logic [7:0] sub_byte [256];
  logic [127:0] key_now = '0;
  round_keys_t key_rounds;
  logic [127:0] sub_k1, sub_k2;
  logic [127:0] running_chain = '0;

  block_beat_t pending_blocks [$];
  tag_beat_t expected_tags [$];
  block_beat_t held_beat;
  logic calm = 1'b0;
  int fails = 0;
  int tags_seen = 0;
  int hold_left = 0;
  bit holdoff_done = 0;
  int quiet_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xtime(a);
    end
    return p;
  endfunction

  // S-box from the field inverse and the affine map
  task automatic build_sub_bytes();
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 0;
      for (int y = 1; y < 256; y++)
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      b = inv;
      sub_byte[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                    ^ {b[3:0], b[7:4]} ^ 8'h63;
    end
  endtask

  function automatic round_keys_t expand_key(input logic [127:0] key);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0] rc;
    round_keys_t rk;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {sub_byte[t[23:16]] ^ rc, sub_byte[t[15:8]], sub_byte[t[7:0]],
             sub_byte[t[31:24]]};
        rc = xtime(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    return rk;
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] blk,
                                               input round_keys_t rk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] st;
    st = blk ^ rk[0];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) s[i] = sub_byte[st[127 - 8*i -: 8]];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i + 4*c] = s[i + 4*((c + i) % 4)];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[127 - 8*i -: 8] = t[i];
      st ^= rk[r];
    end
    return st;
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] a);
    return {a[126:0], 1'b0} ^ (a[127] ? 128'h87 : 128'h0);
  endfunction

  // one CBC step; on the last block apply padding and the matching subkey
  function automatic logic [127:0] chain_block(input block_beat_t b,
                                               input logic [127:0] chain);
    logic [127:0] m;
    m = {b.blk_hi, b.blk_lo};
    if (b.last) begin
      if (b.count >= 16) begin
        m ^= sub_k1;
      end else begin
        for (int i = 0; i < 16; i++) begin
          if (i == b.count) m[127 - 8*i -: 8] = acmac_pkg::PAD_MARK;
          else if (i > b.count) m[127 - 8*i -: 8] = 8'h00;
        end
        m ^= sub_k2;
      end
    end
    return aes_encrypt(m ^ chain, key_rounds);
  endfunction

  task automatic write_key(input logic [0:0] idx, input logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == KEY_UPPER_REG) key_now[127:64] = v;
    else key_now[63:0] = v;
    key_rounds = expand_key(key_now);
    sub_k1 = gf_double(aes_encrypt('0, key_rounds));
    sub_k2 = gf_double(sub_k1);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic absorb_beat(input block_beat_t b);
    logic [127:0] c;
    tag_beat_t tg;
    c = chain_block(b, running_chain);
    if (b.last) begin
      running_chain = '0;
      tg.hi = c[127:64];
      tg.lo = c[63:0];
      tg.match = b.check && (c == {b.exp_hi, b.exp_lo});
      expected_tags.push_back(tg);
    end else begin
      running_chain = c;
    end
  endtask

  // queue a whole message; the expected-tag field is right, one bit off or random
  task automatic queue_message(input int nblk, input int last_count, input int mode);
    block_beat_t b;
    logic [127:0] c, tag;
    int bitpos;
    c = '0;
    for (int k = 0; k < nblk; k++) begin
      b.blk_hi = {$urandom, $urandom};
      b.blk_lo = {$urandom, $urandom};
      b.last = (k == nblk - 1);
      b.count = b.last ? last_count[4:0] : 5'($urandom_range(31));
      b.check = $urandom_range(1);
      b.exp_hi = {$urandom, $urandom};
      b.exp_lo = {$urandom, $urandom};
      if (b.last) begin
        tag = chain_block(b, c);
        if (mode != 2) begin
          bitpos = $urandom_range(127);
          if (mode == 1) tag[bitpos] = ~tag[bitpos];
          {b.exp_hi, b.exp_lo} = tag;
        end
      end else begin
        c = chain_block(b, c);
      end
      pending_blocks.push_back(b);
    end
  endtask

  function automatic int pick_last_count();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(17, 31);
    if (r < 35) return 16;
    return $urandom_range(15);
  endfunction

  task automatic queue_random(input int n);
    int target;
    target = pending_blocks.size() + n;
    while (pending_blocks.size() < target)
      queue_message($urandom_range(99) < 60 ? $urandom_range(1, 2) : $urandom_range(3, 6),
                    pick_last_count(), $urandom_range(2));
  endtask

  task automatic settle();
    while (pending_blocks.size() > 0 || in_valid || expected_tags.size() > 0)
      @(posedge clk);
    // non-last blocks give no tag; let the engine finish them
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fails++;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_beat(held_beat);
      if (!in_valid || in_ready) begin
        if (pending_blocks.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
          held_beat = pending_blocks.pop_front();
          in_valid <= 1'b1;
          in_block_upper <= held_beat.blk_hi;
          in_block_lower <= held_beat.blk_lo;
          in_byte_count <= held_beat.count;
          in_last_block <= held_beat.last;
          in_check_tag <= held_beat.check;
          in_expected_upper <= held_beat.exp_hi;
          in_expected_lower <= held_beat.exp_lo;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    tag_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        tags_seen++;
        if (expected_tags.size() == 0) begin
          report("unexpected tag beat", out_tag_upper, 64'h0);
        end else begin
          want = expected_tags.pop_front();
          if (out_tag_upper !== want.hi) report("tag_upper", out_tag_upper, want.hi);
          if (out_tag_lower !== want.lo) report("tag_lower", out_tag_lower, want.lo);
          if (out_tag_match !== want.match)
            report("tag_match", 64'(out_tag_match), 64'(want.match));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!holdoff_done && tags_seen == 40) begin
        // long hold-off so the engine backs up into the sender
        holdoff_done = 1;
        hold_left = HOLDOFF_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || $urandom_range(99) >= 29;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("aes128_cmac_tag_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    block_beat_t b;
    build_sub_bytes();
    key_rounds = expand_key(key_now);
    sub_k1 = gf_double(aes_encrypt('0, key_rounds));
    sub_k2 = gf_double(sub_k1);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset key, count extremes, padding and compare cases
    queue_message(1, 16, 0);
    queue_message(1, 0, 0);
    queue_message(1, 1, 1);
    queue_message(1, 15, 0);
    queue_message(1, 31, 0);
    queue_message(1, 17, 1);
    queue_message(2, 16, 0);
    queue_message(2, 0, 0);
    queue_message(3, 8, 2);
    b = '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd16, 1'b1, 1'b1,
          64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff};
    pending_blocks.push_back(b);
    b = '{64'h0, 64'h0, 5'd0, 1'b1, 1'b0, 64'h0, 64'h0};
    pending_blocks.push_back(b);
    // leave a message open across the key change
    b = '{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd31, 1'b0, 1'b1,
          64'h0, 64'h0};
    pending_blocks.push_back(b);
    settle();

    write_key(KEY_UPPER_REG, 64'hffff_ffff_ffff_ffff);
    write_key(KEY_LOWER_REG, 64'hffff_ffff_ffff_ffff);
    queue_message(1, 16, 0);
    queue_random(280);
    settle();

    write_key(KEY_UPPER_REG, 64'h2b7e_1516_28ae_d2a6);
    write_key(KEY_LOWER_REG, 64'habf7_1588_09cf_4f3c);
    calm = 1'b1;
    queue_random(300);
    settle();
    calm = 1'b0;

    write_key(KEY_LOWER_REG, {$urandom, $urandom});
    queue_random(290);
    settle();

    write_key(KEY_UPPER_REG, {$urandom, $urandom});
    write_key(KEY_LOWER_REG, {$urandom, $urandom});
    queue_random(290);
    settle();

    write_key(KEY_UPPER_REG, 64'h0);
    write_key(KEY_LOWER_REG, 64'h0);
    queue_random(280);
    settle();

    write_key(KEY_UPPER_REG, {$urandom, $urandom});
    queue_random(290);
    settle();

    if (fails == 0) begin
      $display("aes128_cmac_tag_core verification clean");
    end else begin
      $display("aes128_cmac_tag_core verification failed");
    end
    $finish;
  end

endmodule

>>> aes128_cmac_tag_core.f
hdl/acmac_pkg.sv
hdl/acmac_round.sv
hdl/aes128_cmac_tag_core.sv
bench/aes128_cmac_tag_core_tb.sv
